### rtl/kti_pkg.sv
package kti_pkg;

    localparam int MaxKeyframes = 8;

    // Operation codes of an input request.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_FEW   = 2'd2,
        ST_SPAN  = 2'd3
    } t_status;

    // One request as it leaves the front part.
    typedef struct packed {
        t_op         op;
        logic [16:0] pos;
        logic [31:0] value;
        logic [63:0] colour;
    } t_req;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] value;
        logic [63:0] colour;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_DIV,
        S_LERP,
        S_OUT
    } t_state;

endpackage

### rtl/kti_ram.sv
module kti_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kti_front.sv
module kti_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kti_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output kti_pkg::t_req  o_req
);

    // Two-entry queue between the stream input and the back part.
    kti_pkg::t_req r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_req   = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
`endif

endmodule

### rtl/kti_back.sv
module kti_back #(
    parameter int MaxKeyframes = kti_pkg::MaxKeyframes
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kti_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output kti_pkg::t_res  o_res
);

    localparam int Aw = $clog2(MaxKeyframes);
    localparam int Cw = $clog2(MaxKeyframes + 1);
    localparam int Ew = 17 + 32 + 64;

    kti_pkg::t_state  r_state, n_state;
    logic [Cw-1:0]    r_count;
    logic [Cw-1:0]    r_idx;
    kti_pkg::t_req    r_req;
    logic [Ew-1:0]    r_lo;
    logic [Ew-1:0]    r_hi;
    logic [16:0]      r_num;
    logic [16:0]      r_span;
    logic [16:0]      r_rem;
    logic [16:0]      r_frac;
    logic [4:0]       r_step;
    logic [2:0]       r_lane;
    kti_pkg::t_res    r_res;
    logic             r_ovalid;
    logic             r_first;

    logic             w_we;
    logic [Aw-1:0]    w_raddr;
    logic [Ew-1:0]    w_rdata;
    logic [16:0]      w_rpos;
    logic             w_accept;
    logic             w_stop;
    kti_pkg::t_status w_st;
    logic [17:0]      w_sh;
    logic [17:0]      w_sub;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == kti_pkg::S_IDLE) && !r_ovalid;
    assign w_we     = w_accept && (i_req.op == kti_pkg::OP_APPEND)
                      && (r_count < Cw'(MaxKeyframes));
    assign w_rpos   = w_rdata[Ew-1 -: 17];

    // The search ends at the first keyframe past the query or at the last one.
    assign w_stop   = (r_state == kti_pkg::S_SEARCH) && !r_first
                      && (w_rpos > r_req.pos || r_idx == r_count - Cw'(1));

    // The read address runs one ahead while searching.
    assign w_raddr  = (r_state == kti_pkg::S_SEARCH && !r_first && !w_stop)
                      ? Aw'(r_idx + Cw'(1)) : r_idx[Aw-1:0];

    // Divider step: shift the remainder and try to subtract the span.
    assign w_sh     = {r_rem, 1'b0};
    assign w_sub    = w_sh - {1'b0, r_span};

    // Status of a request that is settled at acceptance.
    always_comb begin
        w_st = kti_pkg::ST_OK;
        if (i_req.op == kti_pkg::OP_APPEND && r_count >= Cw'(MaxKeyframes)) begin
            w_st = kti_pkg::ST_FULL;
        end else if (i_req.op == kti_pkg::OP_QUERY && r_count < Cw'(2)) begin
            w_st = kti_pkg::ST_FEW;
        end
    end

    // Keyframe store: position, scalar and colour in one word.
    kti_ram #(.Width(Ew), .Depth(MaxKeyframes)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[Aw-1:0]),
        .i_wdata ({i_req.pos, i_req.value, i_req.colour}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Lerp of one lane: lo + floor((hi - lo) * f / 65536).
    logic signed [33:0] w_a;
    logic signed [33:0] w_b;
    logic signed [33:0] w_d;
    logic signed [51:0] w_prod;
    logic        [31:0] w_lerp;
    always_comb begin
        if (r_lane == 3'd0) begin
            w_a = 34'(signed'(r_lo[95:64]));
            w_b = 34'(signed'(r_hi[95:64]));
        end else begin
            w_a = signed'({18'd0, r_lo[16*(r_lane-3'd1) +: 16]});
            w_b = signed'({18'd0, r_hi[16*(r_lane-3'd1) +: 16]});
        end
        w_d    = w_b - w_a;
        w_prod = w_d * signed'({1'b0, r_frac});
        w_lerp = 32'(w_a + 34'(w_prod >>> 16));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kti_pkg::S_IDLE: begin
                if (w_accept && i_req.op == kti_pkg::OP_QUERY
                    && r_count >= Cw'(2)) begin
                    n_state = kti_pkg::S_SEARCH;
                end
            end
            kti_pkg::S_SEARCH: begin
                if (w_stop) begin
                    n_state = kti_pkg::S_READ;
                end
            end
            kti_pkg::S_READ:  n_state = kti_pkg::S_DIV;
            kti_pkg::S_DIV: begin
                if (r_step == 5'd17) begin
                    n_state = kti_pkg::S_LERP;
                end
            end
            kti_pkg::S_LERP: begin
                if (r_lane == 3'd4) begin
                    n_state = kti_pkg::S_OUT;
                end
            end
            kti_pkg::S_OUT:   n_state = kti_pkg::S_IDLE;
            default:          n_state = kti_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Keyframe count and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept) begin
                if (i_req.op == kti_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end else if (w_we) begin
                    r_count <= r_count + Cw'(1);
                end
                if (!(i_req.op == kti_pkg::OP_QUERY && r_count >= Cw'(2))) begin
                    r_ovalid <= 1'b1;
                end
            end else if (r_state == kti_pkg::S_OUT) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    // Datapath: search, divide, lerp.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kti_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_req   <= i_req;
                    r_idx   <= '0;
                    r_first <= 1'b1;
                    r_res   <= '{status: w_st, value: '0, colour: '0};
                end
            end
            kti_pkg::S_SEARCH: begin
                r_first <= 1'b0;
                if (!r_first) begin
                    r_lo <= r_hi;
                    r_hi <= w_rdata;
                    if (w_stop) begin
                        // A query before the first keyframe takes keyframe 0.
                        if (r_idx == '0) begin
                            r_res.value  <= w_rdata[95:64];
                            r_res.colour <= w_rdata[63:0];
                        end
                    end else begin
                        r_idx <= r_idx + Cw'(1);
                    end
                end
            end
            kti_pkg::S_READ: begin
                r_span <= r_hi[Ew-1 -: 17] - r_lo[Ew-1 -: 17];
                if (r_req.pos < r_lo[Ew-1 -: 17]) begin
                    r_num <= '0;
                end else begin
                    r_num <= r_req.pos - r_lo[Ew-1 -: 17];
                end
                r_lane <= '0;
                if (r_idx == '0 || r_hi[Ew-1 -: 17] <= r_lo[Ew-1 -: 17]) begin
                    r_step <= 5'd17;
                end else begin
                    r_step <= '0;
                end
                // Zero or negative span returns the lower keyframe.
                if (r_idx != '0 && r_hi[Ew-1 -: 17] <= r_lo[Ew-1 -: 17]) begin
                    r_res <= '{status: kti_pkg::ST_SPAN, value: r_lo[95:64],
                               colour: r_lo[63:0]};
                end
            end
            kti_pkg::S_DIV: begin
                if (r_step == 5'd0) begin
                    // The integer bit of the fraction; an offset past the
                    // span clamps the fraction to 1.0.
                    if (r_num >= r_span) begin
                        r_rem  <= '0;
                        r_frac <= 17'd1;
                    end else begin
                        r_rem  <= r_num;
                        r_frac <= '0;
                    end
                    r_step <= 5'd1;
                end else if (r_step != 5'd17) begin
                    // Restoring division, one fraction bit per step.
                    if (w_sh >= {1'b0, r_span}) begin
                        r_rem  <= w_sub[16:0];
                        r_frac <= {r_frac[15:0], 1'b1};
                    end else begin
                        r_rem  <= w_sh[16:0];
                        r_frac <= {r_frac[15:0], 1'b0};
                    end
                    r_step <= r_step + 5'd1;
                end
            end
            kti_pkg::S_LERP: begin
                r_lane <= r_lane + 3'd1;
                if (r_res.status == kti_pkg::ST_OK && r_idx != '0) begin
                    if (r_lane == 3'd0) begin
                        r_res.value <= w_lerp;
                    end else begin
                        r_res.colour[16*(r_lane-3'd1) +: 16] <= w_lerp[15:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_ovalid && (r_state == kti_pkg::S_IDLE);
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Cw'(MaxKeyframes)) else $error("keyframe count overflow");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != kti_pkg::S_IDLE |-> !o_ready) else $error("ready while busy");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kti_pkg::S_OUT |=> r_ovalid) else $error("result lost");
`endif

endmodule

### rtl/keyframe_timeline_interpolator.sv
// Keyframe timeline interpolator. Requests (clear, append, query) enter a
// two-deep queue and are executed one at a time; every request gives one
// result, and the next request is taken only after that result has left.
// Clear, append, the unused code and a query on fewer than two keyframes
// present their result on the cycle after acceptance. A query with at least
// two keyframes goes through these steps after acceptance: the keyframe
// memory read is started, the keyframes are searched in order, span and
// offset are formed, the bit-serial fraction divider runs, the shared lerp
// multiplier serves the value and each colour lane in turn, and the result is
// handed over. A query stopping before the first keyframe or on a zero span
// skips the divider steps.
module keyframe_timeline_interpolator #(
    parameter int MAX_KEYFRAMES = kti_pkg::MaxKeyframes
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0], position[18:2], value_in[50:19], red_in[66:51],
    // green_in[82:67], blue_in[98:83], alpha_in[114:99], zero pad to 120
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], value_out[33:2], red_out[49:34], green_out[65:50],
    // blue_out[81:66], alpha_out[97:82], zero pad to 104
    output logic [103:0] m_axis_tdata
);

    kti_pkg::t_req w_in;
    kti_pkg::t_req w_q;
    kti_pkg::t_res w_res;
    logic          w_qv;
    logic          w_qr;

    assign w_in.op     = kti_pkg::t_op'(s_axis_tdata[1:0]);
    assign w_in.pos    = s_axis_tdata[18:2];
    assign w_in.value  = s_axis_tdata[50:19];
    assign w_in.colour = s_axis_tdata[114:51];

    kti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (w_in),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_req   (w_q)
    );

    kti_back #(.MaxKeyframes(MAX_KEYFRAMES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .i_req   (w_q),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.colour, w_res.value, w_res.status};

endmodule
